// ===== sv/cfm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfm_pkg
// Shared widths, character codes, micro-operation codes and the control store
// of the capture frequency meter.
// ----------------------------------------------------------------------------
package cfm_pkg;

  localparam int CAP_W       = 16;
  localparam int CLK_W       = 24;
  localparam int CHAR_W      = 6;
  localparam int DIGIT_COUNT = 5;
  localparam int BCD_W       = 4 * DIGIT_COUNT;
  localparam int BIN_W       = 16;
  localparam int CNT_W       = 5;
  localparam int PC_W        = 3;

  localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET = 24'd1048576;
  localparam logic [CHAR_W-1:0] CHAR_ZERO      = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 6'd32;
  localparam logic [CHAR_W-1:0] CHAR_FIVE      = 6'd53;
  localparam logic [CHAR_W-1:0] CHAR_SIX       = 6'd54;

  // micro-operations driving the datapath
  localparam logic [2:0] OP_ACCEPT = 3'd0;
  localparam logic [2:0] OP_DIV    = 3'd1;
  localparam logic [2:0] OP_CLAMP  = 3'd2;
  localparam logic [2:0] OP_BCD    = 3'd3;
  localparam logic [2:0] OP_EMIT   = 3'd4;

  // sequencing modes
  localparam logic [1:0] BR_ACCEPT = 2'd0;
  localparam logic [1:0] BR_LOOP   = 2'd1;
  localparam logic [1:0] BR_NEXT   = 2'd2;
  localparam logic [1:0] BR_WAIT   = 2'd3;

  // control store addresses
  localparam logic [PC_W-1:0] UPC_ACCEPT = 3'd0;
  localparam logic [PC_W-1:0] UPC_DIV    = 3'd1;
  localparam logic [PC_W-1:0] UPC_CLAMP  = 3'd2;
  localparam logic [PC_W-1:0] UPC_BCD    = 3'd3;
  localparam logic [PC_W-1:0] UPC_EMIT   = 3'd4;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(CLK_W - 1);
  localparam logic [CNT_W-1:0] BCD_LAST = CNT_W'(BIN_W - 1);

  typedef struct packed {
    logic [2:0]       op;
    logic [1:0]       br;
    logic [PC_W-1:0]  target;
    logic [PC_W-1:0]  alt;
    logic [CNT_W-1:0] cnt_init;
  } ucode_t;

  typedef struct packed {
    logic [2:0] op;
  } ctrl_t;

  typedef struct packed {
    logic take;
    logic launch;
    logic zero;
    logic out_free;
  } sts_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      UPC_ACCEPT: w = '{OP_ACCEPT, BR_ACCEPT, UPC_DIV, UPC_EMIT, DIV_LAST};
      UPC_DIV:    w = '{OP_DIV, BR_LOOP, UPC_CLAMP, UPC_ACCEPT, '0};
      UPC_CLAMP:  w = '{OP_CLAMP, BR_NEXT, UPC_BCD, UPC_ACCEPT, BCD_LAST};
      UPC_BCD:    w = '{OP_BCD, BR_LOOP, UPC_EMIT, UPC_ACCEPT, '0};
      UPC_EMIT:   w = '{OP_EMIT, BR_WAIT, UPC_ACCEPT, UPC_ACCEPT, '0};
      default:    w = '{OP_ACCEPT, BR_NEXT, UPC_ACCEPT, UPC_ACCEPT, '0};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/cfm_sequencer.sv =====
// ----------------------------------------------------------------------------
// cfm_sequencer
// Step counter, loop counter and control store; issues one micro-operation
// per cycle to the datapath.
// ----------------------------------------------------------------------------
module cfm_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  cfm_pkg::sts_t sts,
  output cfm_pkg::ctrl_t ctrl
);
  import cfm_pkg::*;

  logic [PC_W-1:0]  pc;
  logic [CNT_W-1:0] cnt;
  ucode_t           word;

  assign word    = ucode_rom(pc);
  assign ctrl.op = word.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= UPC_ACCEPT;
      cnt <= '0;
    end else begin
      case (word.br)
        BR_ACCEPT: begin
          // ignored or unchanged transactions keep us here
          if (sts.take && sts.launch) begin
            pc  <= sts.zero ? word.alt : word.target;
            cnt <= word.cnt_init;
          end
        end
        BR_LOOP: begin
          if (cnt == '0) begin
            pc  <= word.target;
            cnt <= word.cnt_init;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        BR_NEXT: begin
          pc  <= word.target;
          cnt <= word.cnt_init;
        end
        BR_WAIT: begin
          if (sts.out_free) begin
            pc  <= word.target;
            cnt <= word.cnt_init;
          end
        end
        default: begin
          pc <= UPC_ACCEPT;
        end
      endcase
    end
  end

endmodule

// ===== sv/capture_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// capture_frequency_meter
// Reciprocal frequency counter: clock_hz / capture period, shown as five
// ASCII characters with leading blanks.
// Steps from input transaction to out_valid: 24 divide steps, one clamp
// step, 16 decimal conversion steps, one output load; a zero period goes
// straight to the output load, and an ignored or unchanged pair gives no result.
// The input is held off until a transaction has passed its output load, as
// the one-bit-per-cycle divider and the shift-and-add-3 converter share one
// sequencer; the output load also waits while an earlier result is stalled.
// Reset (rst, synchronous): clock_hz back to 1048576, no period recorded,
// output empty.
// ----------------------------------------------------------------------------
module capture_frequency_meter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cfm_pkg::CAP_W-1:0]    capture_start,
  input  logic [cfm_pkg::CAP_W-1:0]    capture_end,
  input  logic                         cfg_write,
  input  logic [cfm_pkg::CLK_W-1:0]    cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cfm_pkg::CHAR_W-1:0]   digit_4,
  output logic [cfm_pkg::CHAR_W-1:0]   digit_3,
  output logic [cfm_pkg::CHAR_W-1:0]   digit_2,
  output logic [cfm_pkg::CHAR_W-1:0]   digit_1,
  output logic [cfm_pkg::CHAR_W-1:0]   digit_0,
  output logic                         zero_period,
  output logic                         saturated
);
  import cfm_pkg::*;

  ctrl_t ctrl;
  sts_t  sts;

  logic [CLK_W-1:0]  clock_hz;
  logic [CAP_W-1:0]  last_period;
  logic              have_period;

  logic [CAP_W-1:0]  period;
  logic              ignore_pair;
  logic              unchanged;
  logic              take;
  logic              emit;

  logic [CLK_W-1:0]  quot;
  logic [CAP_W-1:0]  rem;
  logic [CAP_W-1:0]  divisor;
  logic [CAP_W:0]    rem_sh;
  logic [CAP_W:0]    rem_diff;
  logic              rem_ge;
  logic              zero_flag;
  logic              sat_flag;
  logic              sat_now;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [CHAR_W-1:0] chars [DIGIT_COUNT];

  cfm_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .sts  (sts),
    .ctrl (ctrl)
  );

  assign period      = capture_end - capture_start;
  assign ignore_pair = (capture_start == '0) && (capture_end == '0);
  // within one count of the last period, compared without wrap
  assign unchanged   = have_period &&
                       ({1'b0, period} <= {1'b0, last_period} + 1'b1) &&
                       ({1'b0, period} + 1'b1 >= {1'b0, last_period});

  assign in_stall = (ctrl.op != OP_ACCEPT);
  assign take     = in_valid && !in_stall;
  assign emit     = (ctrl.op == OP_EMIT) && sts.out_free;

  assign sts.take     = take;
  assign sts.launch   = !ignore_pair && !unchanged;
  assign sts.zero     = (period == '0);
  assign sts.out_free = !out_valid || !out_stall;

  // restoring divide, one quotient bit per step
  assign rem_sh   = {rem, quot[CLK_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign sat_now  = |quot[CLK_W-1:BIN_W];

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // leading zeros blank, units shown unless the period is zero (all blank then)
  always_comb begin
    logic lead;
    lead = 1'b1;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      lead = lead && (bcd[4*i +: 4] == 4'd0) && (i != 0);
      if (zero_flag || lead) begin
        chars[i] = CHAR_SPACE;
      end else begin
        chars[i] = CHAR_ZERO + {2'b00, bcd[4*i +: 4]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz    <= CLOCK_HZ_RESET;
      last_period <= '0;
      have_period <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        clock_hz <= cfg_data;
      end
      if (take && sts.launch) begin
        last_period <= period;
        have_period <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (take && sts.launch) begin
          quot      <= clock_hz;
          rem       <= '0;
          divisor   <= period;
          zero_flag <= sts.zero;
          sat_flag  <= 1'b0;
          bcd       <= '0;
        end
      end
      OP_DIV: begin
        rem  <= rem_ge ? rem_diff[CAP_W-1:0] : rem_sh[CAP_W-1:0];
        quot <= {quot[CLK_W-2:0], rem_ge};
      end
      OP_CLAMP: begin
        sat_flag <= sat_now;
        quot     <= {{(CLK_W-BIN_W){1'b0}}, sat_now ? {BIN_W{1'b1}} : quot[BIN_W-1:0]};
      end
      OP_BCD: begin
        bcd  <= {bcd_adj[BCD_W-2:0], quot[BIN_W-1]};
        quot <= {quot[CLK_W-1:BIN_W], quot[BIN_W-2:0], 1'b0};
      end
      OP_EMIT: begin
        if (emit) begin
          digit_4     <= chars[4];
          digit_3     <= chars[3];
          digit_2     <= chars[2];
          digit_1     <= chars[1];
          digit_0     <= chars[0];
          zero_period <= zero_flag;
          saturated   <= sat_flag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/cfm_checker.sv =====
// ----------------------------------------------------------------------------
// cfm_checker
// Port-level checks of the capture frequency meter, bound to the top level.
// ----------------------------------------------------------------------------
module cfm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [cfm_pkg::CHAR_W-1:0] digit_4,
  input logic [cfm_pkg::CHAR_W-1:0] digit_0,
  input logic                       zero_period,
  input logic                       saturated
);
  import cfm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // results are only loaded while the input side is held off
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input was open");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

  // zero period shows blanks and is never flagged as clamped
  a_zero_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_period |-> digit_0 == CHAR_SPACE && !saturated)
    else $error("zero period transaction not blank");

  // a clamped quotient reads 65535
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> digit_4 == CHAR_SIX && digit_0 == CHAR_FIVE)
    else $error("clamped transaction does not show 65535");

endmodule

bind capture_frequency_meter cfm_checker u_cfm_checker (.*);
